// ===== src/cpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpb_pkg
// Shared constants, codes and types of the CPU placement and balance block.
// ----------------------------------------------------------------------------
package cpb_pkg;

   // number of per-CPU slots and derived widths
   localparam int NUM_CPU_SLOTS = 8;
   localparam int CPU_W = $clog2(NUM_CPU_SLOTS);
   localparam int CNT_W = $clog2(NUM_CPU_SLOTS + 1);
   localparam int CMP_W = ((CPU_W > 3) ? CPU_W : 3) + 1;

   // payload widths
   localparam int LOAD_W  = 16;
   localparam int TICK_W  = 8;
   localparam int TOTAL_W = 19;

   localparam logic [LOAD_W-1:0]  LOAD_MAX  = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // request function codes
   localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
   localparam logic [1:0] FUNC_REMOVE  = 2'd1;
   localparam logic [1:0] FUNC_TICK    = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_ACTIVE_CPUS      = 2'd0;
   localparam logic [1:0] CSR_BALANCE_PERIOD   = 2'd1;
   localparam logic [1:0] CSR_IMBALANCE_MARGIN = 2'd2;

   // configuration reset values
   localparam logic [3:0] ACTIVE_CPUS_RST      = 4'd1;
   localparam logic [7:0] BALANCE_PERIOD_RST   = 8'd100;
   localparam logic [3:0] IMBALANCE_MARGIN_RST = 4'd2;

   // sequencer to scan unit control
   typedef struct packed {
      logic              clear;
      logic              step;
      logic              active;
      logic              own;
      logic              mask_bit;
      logic              first;
      logic [CPU_W-1:0]  idx;
      logic [LOAD_W-1:0] load;
   } scan_ctrl_type;

   // scan unit accumulators
   typedef struct packed {
      logic [LOAD_W-1:0]  min_val;
      logic [CPU_W-1:0]   min_idx;
      logic [LOAD_W-1:0]  max_val;
      logic [LOAD_W-1:0]  best_val;
      logic [CPU_W-1:0]   best_idx;
      logic [LOAD_W-1:0]  own_val;
      logic               mask_found;
      logic [CPU_W-1:0]   mask_idx;
      logic [LOAD_W-1:0]  mask_val;
      logic [LOAD_W-1:0]  zero_val;
      logic [TOTAL_W-1:0] total;
   } scan_res_type;

   // write port of the per-CPU state
   typedef struct packed {
      logic              load_we;
      logic [CPU_W-1:0]  load_addr;
      logic [LOAD_W-1:0] load_wdata;
      logic              tick_we;
      logic [TICK_W-1:0] tick_wdata;
   } store_wr_type;

endpackage

// ===== src/cpb_load_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpb_load_store
// Per-CPU thread counts and balance counters, one write and one read each.
// ----------------------------------------------------------------------------
module cpb_load_store (
   input  logic                        clock,
   input  logic                        reset,
   input  cpb_pkg::store_wr_type       wr,
   input  logic [cpb_pkg::CPU_W-1:0]   load_rd_addr,
   input  logic [cpb_pkg::CPU_W-1:0]   tick_addr,
   output logic [cpb_pkg::LOAD_W-1:0]  load_rd_data,
   output logic [cpb_pkg::TICK_W-1:0]  tick_rd_data
);

   logic [cpb_pkg::LOAD_W-1:0] load_ff [cpb_pkg::NUM_CPU_SLOTS];
   logic [cpb_pkg::TICK_W-1:0] tick_ff [cpb_pkg::NUM_CPU_SLOTS];

   // read ports
   assign load_rd_data = load_ff[load_rd_addr];
   assign tick_rd_data = tick_ff[tick_addr];

   // write ports, all counts cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cpb_pkg::NUM_CPU_SLOTS; i++) begin
            load_ff[i] <= '0;
            tick_ff[i] <= '0;
         end
      end else begin
         if (wr.load_we) begin
            load_ff[wr.load_addr] <= wr.load_wdata;
         end
         if (wr.tick_we) begin
            tick_ff[tick_addr] <= wr.tick_wdata;
         end
      end
   end

endmodule

// ===== src/cpb_scan_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpb_scan_unit
// Shared compare and accumulate unit; takes one CPU load per cycle.
// ----------------------------------------------------------------------------
module cpb_scan_unit (
   input  logic                   clock,
   input  cpb_pkg::scan_ctrl_type ctl,
   output cpb_pkg::scan_res_type  res
);

   cpb_pkg::scan_res_type res_ff;
   cpb_pkg::scan_res_type res_in;
   logic [cpb_pkg::TOTAL_W:0] sum;

   assign res = res_ff;
   assign sum = {1'b0, res_ff.total} + (cpb_pkg::TOTAL_W + 1)'(ctl.load);

   // one element per step: min, max, best other, sum and captures
   always_comb begin
      res_in = res_ff;
      if (ctl.clear) begin
         res_in.min_val    = cpb_pkg::LOAD_MAX;
         res_in.min_idx    = '0;
         res_in.max_val    = '0;
         res_in.best_val   = '0;
         res_in.best_idx   = '0;
         res_in.mask_found = 1'b0;
         res_in.mask_idx   = '0;
         res_in.total      = '0;
      end else if (ctl.step) begin
         if (ctl.active) begin
            if (ctl.load < res_ff.min_val) begin
               res_in.min_val = ctl.load;
               res_in.min_idx = ctl.idx;
            end
            if (ctl.load > res_ff.max_val) begin
               res_in.max_val = ctl.load;
            end
            if (!ctl.own && (ctl.load > res_ff.best_val)) begin
               res_in.best_val = ctl.load;
               res_in.best_idx = ctl.idx;
            end
            if (sum > (cpb_pkg::TOTAL_W + 1)'(cpb_pkg::TOTAL_MAX)) begin
               res_in.total = cpb_pkg::TOTAL_MAX;
            end else begin
               res_in.total = sum[cpb_pkg::TOTAL_W-1:0];
            end
            if (ctl.mask_bit && !res_ff.mask_found) begin
               res_in.mask_found = 1'b1;
               res_in.mask_idx   = ctl.idx;
               res_in.mask_val   = ctl.load;
            end
         end
         if (ctl.own) begin
            res_in.own_val = ctl.load;
         end
         if (ctl.first) begin
            res_in.zero_val = ctl.load;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule

// ===== src/cpu_placement_and_balance_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_placement_and_balance_top
// Least-loaded CPU placement with periodic imbalance check and steal choice.
//
//   channel   handshake            payload
//   request   start / busy         req_func, req_affinity_mask, req_cpu_id
//   result    rsp_valid (1 cycle)  rsp_placed_cpu, rsp_steal_request,
//                                  rsp_steal_source, rsp_imbalanced,
//                                  rsp_total_load
//   config    csr_write_en         csr_index, csr_wdata
//
// A request makes one pass over all slot loads before the update and one
// after it, one load per cycle, with an update state between the passes and a
// finish state after them; the result strobe is registered from the finish state.
// busy is high from the accept until the result is shown; the next request
// may be taken in the cycle the result is on the ports.
// Synchronous reset clears all counts; the receiver cannot stall.
// ----------------------------------------------------------------------------
module cpu_placement_and_balance_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_affinity_mask,
   input  logic [2:0]  req_cpu_id,
   output logic        rsp_valid,
   output logic [2:0]  rsp_placed_cpu,
   output logic        rsp_steal_request,
   output logic [2:0]  rsp_steal_source,
   output logic        rsp_imbalanced,
   output logic [18:0] rsp_total_load,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN1 = 3'd1;
   localparam logic [2:0] ST_UPD   = 3'd2;
   localparam logic [2:0] ST_SCAN2 = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   localparam logic [cpb_pkg::CPU_W-1:0] IDX_LAST = cpb_pkg::CPU_W'(cpb_pkg::NUM_CPU_SLOTS - 1);

   logic [2:0]                   state_ff, state_in;
   logic [cpb_pkg::CPU_W-1:0]    idx_ff, idx_in;
   logic [1:0]                   func_ff, func_in;
   logic [7:0]                   mask_ff, mask_in;
   logic [2:0]                   cpu_ff, cpu_in;
   logic [cpb_pkg::CNT_W-1:0]    n_ff, n_in;
   logic [3:0]                   active_ff;
   logic [7:0]                   period_ff;
   logic [3:0]                   margin_ff;
   logic [cpb_pkg::CPU_W-1:0]    target_ff, target_in;
   logic                         steal_ff, steal_in;
   logic [cpb_pkg::CPU_W-1:0]    source_ff, source_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [2:0]                   rsp_target_ff, rsp_target_in;
   logic                         rsp_steal_ff, rsp_steal_in;
   logic [2:0]                   rsp_source_ff, rsp_source_in;
   logic                         rsp_imb_ff, rsp_imb_in;
   logic [18:0]                  rsp_total_ff, rsp_total_in;

   cpb_pkg::scan_ctrl_type       scan_ctl;
   cpb_pkg::scan_res_type        scan_res;
   cpb_pkg::store_wr_type        store_wr;
   logic [cpb_pkg::LOAD_W-1:0]   rd_load;
   logic [cpb_pkg::TICK_W-1:0]   rd_tick;
   logic [cpb_pkg::CPU_W-1:0]    cpu_idx;
   logic [7:0]                   mask_sh;
   logic [cpb_pkg::CNT_W-1:0]    n_live;
   logic                         accept;
   logic                         cpu_ok;
   logic                         spread;
   logic [cpb_pkg::CPU_W-1:0]    enq_idx;
   logic [cpb_pkg::LOAD_W-1:0]   enq_val;
   logic [7:0]                   period_eff;
   logic [8:0]                   tick_next;
   logic [cpb_pkg::LOAD_W:0]     steal_floor;

   // handshake
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // per-CPU state
   cpb_load_store u_store (
      .clock        (clock),
      .reset        (reset),
      .wr           (store_wr),
      .load_rd_addr (idx_ff),
      .tick_addr    (cpu_idx),
      .load_rd_data (rd_load),
      .tick_rd_data (rd_tick)
   );

   // shared compare unit
   cpb_scan_unit u_scan (
      .clock (clock),
      .ctl   (scan_ctl),
      .res   (scan_res)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= cpb_pkg::ACTIVE_CPUS_RST;
         period_ff <= cpb_pkg::BALANCE_PERIOD_RST;
         margin_ff <= cpb_pkg::IMBALANCE_MARGIN_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            cpb_pkg::CSR_ACTIVE_CPUS:      active_ff <= csr_wdata[3:0];
            cpb_pkg::CSR_BALANCE_PERIOD:   period_ff <= csr_wdata;
            cpb_pkg::CSR_IMBALANCE_MARGIN: margin_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // live cpu count: zero acts as one, clipped to the slot count
   always_comb begin
      if (active_ff == 4'd0) begin
         n_live = cpb_pkg::CNT_W'(1);
      end else if (int'(active_ff) > cpb_pkg::NUM_CPU_SLOTS) begin
         n_live = cpb_pkg::CNT_W'(cpb_pkg::NUM_CPU_SLOTS);
      end else begin
         n_live = cpb_pkg::CNT_W'(active_ff);
      end
   end

   // element fed to the scan unit
   assign cpu_idx = cpb_pkg::CPU_W'(cpu_ff);
   assign cpu_ok  = cpb_pkg::CMP_W'(cpu_ff) < cpb_pkg::CMP_W'(cpb_pkg::NUM_CPU_SLOTS);
   assign mask_sh = mask_ff >> idx_ff;

   always_comb begin
      scan_ctl          = '0;
      scan_ctl.idx      = idx_ff;
      scan_ctl.load     = rd_load;
      scan_ctl.active   = cpb_pkg::CNT_W'(idx_ff) < n_ff;
      scan_ctl.own      = cpb_pkg::CMP_W'(idx_ff) == cpb_pkg::CMP_W'(cpu_ff);
      scan_ctl.mask_bit = mask_sh[0];
      scan_ctl.first    = (idx_ff == '0);
      scan_ctl.clear    = accept || (state_ff == ST_UPD);
      scan_ctl.step     = (state_ff == ST_SCAN1) || (state_ff == ST_SCAN2);
   end

   // spread over the active cpus, from the last completed pass
   assign spread = (n_ff > cpb_pkg::CNT_W'(1)) &&
                   ((scan_res.max_val - scan_res.min_val) > cpb_pkg::LOAD_W'(margin_ff));

   // enqueue target: least loaded if the mask is empty, else first allowed active cpu, else cpu 0
   always_comb begin
      if (mask_ff == 8'd0) begin
         enq_idx = scan_res.min_idx;
         enq_val = scan_res.min_val;
      end else if (scan_res.mask_found) begin
         enq_idx = scan_res.mask_idx;
         enq_val = scan_res.mask_val;
      end else begin
         enq_idx = '0;
         enq_val = scan_res.zero_val;
      end
   end

   // balance counter step and steal threshold
   assign period_eff  = (period_ff == 8'd0) ? 8'd1 : period_ff;
   assign tick_next   = {1'b0, rd_tick} + 9'd1;
   assign steal_floor = {1'b0, scan_res.own_val} + (cpb_pkg::LOAD_W + 1)'(margin_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      func_in       = func_ff;
      mask_in       = mask_ff;
      cpu_in        = cpu_ff;
      n_in          = n_ff;
      target_in     = target_ff;
      steal_in      = steal_ff;
      source_in     = source_ff;
      rsp_valid_in  = 1'b0;
      rsp_target_in = rsp_target_ff;
      rsp_steal_in  = rsp_steal_ff;
      rsp_source_in = rsp_source_ff;
      rsp_imb_in    = rsp_imb_ff;
      rsp_total_in  = rsp_total_ff;
      store_wr      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in  = req_func;
               mask_in  = req_affinity_mask;
               cpu_in   = req_cpu_id;
               n_in     = n_live;
               idx_in   = '0;
               state_in = ST_SCAN1;
            end
         end
         ST_SCAN1: begin
            if (idx_ff == IDX_LAST) begin
               idx_in   = '0;
               state_in = ST_UPD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_UPD: begin
            target_in = '0;
            steal_in  = 1'b0;
            source_in = '0;
            case (func_ff)
               cpb_pkg::FUNC_ENQUEUE: begin
                  target_in           = enq_idx;
                  store_wr.load_we    = 1'b1;
                  store_wr.load_addr  = enq_idx;
                  store_wr.load_wdata = (enq_val == cpb_pkg::LOAD_MAX) ? enq_val
                                                                       : enq_val + 1'b1;
               end
               cpb_pkg::FUNC_REMOVE: begin
                  if (cpu_ok && (scan_res.own_val != '0)) begin
                     store_wr.load_we    = 1'b1;
                     store_wr.load_addr  = cpu_idx;
                     store_wr.load_wdata = scan_res.own_val - 1'b1;
                  end
               end
               cpb_pkg::FUNC_TICK: begin
                  if (cpu_ok && spread) begin
                     store_wr.tick_we = 1'b1;
                     if (tick_next >= {1'b0, period_eff}) begin
                        store_wr.tick_wdata = '0;
                        if ((scan_res.best_val != '0) &&
                            ({1'b0, scan_res.best_val} >= steal_floor)) begin
                           steal_in  = 1'b1;
                           source_in = scan_res.best_idx;
                        end
                     end else begin
                        store_wr.tick_wdata = tick_next[7:0];
                     end
                  end
               end
               default: ;
            endcase
            state_in = ST_SCAN2;
         end
         ST_SCAN2: begin
            if (idx_ff == IDX_LAST) begin
               idx_in   = '0;
               state_in = ST_FIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FIN: begin
            rsp_valid_in  = 1'b1;
            rsp_target_in = 3'(target_ff);
            rsp_steal_in  = steal_ff;
            rsp_source_in = 3'(source_ff);
            rsp_imb_in    = spread;
            rsp_total_in  = scan_res.total;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      mask_ff       <= mask_in;
      cpu_ff        <= cpu_in;
      n_ff          <= n_in;
      target_ff     <= target_in;
      steal_ff      <= steal_in;
      source_ff     <= source_in;
      rsp_target_ff <= rsp_target_in;
      rsp_steal_ff  <= rsp_steal_in;
      rsp_source_ff <= rsp_source_in;
      rsp_imb_ff    <= rsp_imb_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_placed_cpu    = rsp_target_ff;
   assign rsp_steal_request = rsp_steal_ff;
   assign rsp_steal_source  = rsp_source_ff;
   assign rsp_imbalanced    = rsp_imb_ff;
   assign rsp_total_load    = rsp_total_ff;

   // result strobe only once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while sequencer busy");

   // an accepted request always starts the first pass
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN1) && (idx_ff == '0))
      else $error("accepted request did not start scan");

   // steal requests come only from balance ticks
   a_steal_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_steal_request) |-> (func_ff == cpb_pkg::FUNC_TICK))
      else $error("steal request from non-tick request");

   // nonzero placement only on enqueue
   a_target_enq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_placed_cpu != 3'd0)) |-> (func_ff == cpb_pkg::FUNC_ENQUEUE))
      else $error("placed cpu set on non-enqueue request");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CPU placement and balance block. Requests are
// sent through the start/busy handshake with random gaps, and each one is run
// through a local model of the per-CPU loads and balance counters once busy
// falls again. Every result strobe is compared field by field with the
// oldest prediction. Directed tests cover placement rules, register extremes
// and steal decisions; random traffic then runs under several configurations.
// ----------------------------------------------------------------------------
module testbench;
   import cpb_pkg::*;

   // the package leaves code 3 unnamed; the block must ignore it
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int LATENCY    = 2 * NUM_CPU_SLOTS + 3;
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [2:0]         placed_cpu;
      logic               steal_request;
      logic [2:0]         steal_source;
      logic               imbalanced;
      logic [TOTAL_W-1:0] total_load;
   } placement_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_func;
   logic [7:0]         req_affinity_mask;
   logic [2:0]         req_cpu_id;
   logic               rsp_valid;
   logic [2:0]         rsp_placed_cpu;
   logic               rsp_steal_request;
   logic [2:0]         rsp_steal_source;
   logic               rsp_imbalanced;
   logic [TOTAL_W-1:0] rsp_total_load;
   logic               csr_write_en;
   logic [1:0]         csr_index;
   logic [7:0]         csr_wdata;

   // predicted results waiting for their strobe
   placement_type expected_placements[$];

   // local copy of the per-CPU state and the registers
   logic [LOAD_W-1:0] mirror_load [NUM_CPU_SLOTS];
   logic [TICK_W-1:0] mirror_tick [NUM_CPU_SLOTS];
   logic [3:0]        cfg_active;
   logic [7:0]        cfg_period;
   logic [3:0]        cfg_margin;

   int errors      = 0;
   int idle_cycles = 0;
   bit no_gap      = 1'b0;

   cpu_placement_and_balance_top u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_affinity_mask (req_affinity_mask),
      .req_cpu_id        (req_cpu_id),
      .rsp_valid         (rsp_valid),
      .rsp_placed_cpu    (rsp_placed_cpu),
      .rsp_steal_request (rsp_steal_request),
      .rsp_steal_source  (rsp_steal_source),
      .rsp_imbalanced    (rsp_imbalanced),
      .rsp_total_load    (rsp_total_load),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // number of CPUs taking part, out-of-range counts clamped
   function automatic int live_cpus();
      int n;
      n = cfg_active;
      if (n == 0) n = 1;
      if (n > NUM_CPU_SLOTS) n = NUM_CPU_SLOTS;
      return n;
   endfunction

   // max minus min load over the live CPUs compared with the margin
   function automatic bit load_spread_high(input int n);
      int lo;
      int hi;
      if (n <= 1) return 1'b0;
      lo = mirror_load[0];
      hi = mirror_load[0];
      for (int i = 1; i < n; i++) begin
         if (mirror_load[i] < lo) lo = mirror_load[i];
         if (mirror_load[i] > hi) hi = mirror_load[i];
      end
      return (hi - lo) > cfg_margin;
   endfunction

   // apply one request to the local state and return the result it gives
   function automatic placement_type predict_placement(input logic [1:0] func,
                                                       input logic [7:0] mask,
                                                       input logic [2:0] cpu);
      placement_type res;
      int n;
      int target;
      int period;
      int count;
      int best;
      int best_load;
      int total;
      bit found;
      n = live_cpus();
      res = '0;
      target = 0;
      case (func)
         FUNC_ENQUEUE: begin
            if (mask != 8'd0) begin
               // lowest allowed live CPU, CPU 0 when none is live
               for (int i = n - 1; i >= 0; i--) begin
                  if (mask[i]) target = i;
               end
            end else begin
               // least loaded, ties to the lowest index
               for (int i = 1; i < n; i++) begin
                  if (mirror_load[i] < mirror_load[target]) target = i;
               end
            end
            if (mirror_load[target] != LOAD_MAX) mirror_load[target]++;
            res.placed_cpu = target[2:0];
         end
         FUNC_REMOVE: begin
            if (mirror_load[cpu] != '0) mirror_load[cpu]--;
         end
         FUNC_TICK: begin
            if (load_spread_high(n)) begin
               period = (cfg_period == 8'd0) ? 1 : cfg_period;
               count = mirror_tick[cpu] + 1;
               if (count >= period) begin
                  // counter wraps, look for the busiest other CPU
                  mirror_tick[cpu] = '0;
                  best = 0;
                  best_load = 0;
                  found = 1'b0;
                  for (int i = 0; i < n; i++) begin
                     if (i != cpu && mirror_load[i] > best_load) begin
                        best_load = mirror_load[i];
                        best = i;
                        found = 1'b1;
                     end
                  end
                  if (found && best_load >= mirror_load[cpu] + cfg_margin) begin
                     res.steal_request = 1'b1;
                     res.steal_source = best[2:0];
                  end
               end else begin
                  mirror_tick[cpu] = count[7:0];
               end
            end
         end
         default: ;
      endcase
      total = 0;
      for (int i = 0; i < n; i++) total += mirror_load[i];
      if (total > TOTAL_MAX) total = TOTAL_MAX;
      res.total_load = total[TOTAL_W-1:0];
      res.imbalanced = load_spread_high(n);
      return res;
   endfunction

   // one request through the start/busy handshake, predicted once busy falls again
   task automatic send_request(input logic [1:0] func, input logic [7:0] mask,
                               input logic [2:0] cpu);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= func;
      req_affinity_mask <= mask;
      req_cpu_id <= cpu;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_placements.push_back(predict_placement(func, mask, cpu));
   endtask

   // stop sending and wait until every result is back
   task automatic wait_idle();
      start <= 1'b0;
      while (expected_placements.size() != 0) @(posedge clock);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // write all three registers, unused upper bits filled at random
   task automatic set_config(input int active, input int period, input int margin);
      logic [3:0] pad;
      pad = $urandom_range(0, 15);
      csr_write_en <= 1'b1;
      csr_index <= CSR_ACTIVE_CPUS;
      csr_wdata <= {pad, active[3:0]};
      @(posedge clock);
      pad = $urandom_range(0, 15);
      csr_index <= CSR_BALANCE_PERIOD;
      csr_wdata <= period[7:0];
      @(posedge clock);
      csr_index <= CSR_IMBALANCE_MARGIN;
      csr_wdata <= {pad, margin[3:0]};
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_active = active[3:0];
      cfg_period = period[7:0];
      cfg_margin = margin[3:0];
   endtask

   task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                              input logic [TOTAL_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d actual %0d", name, want, got);
         errors++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      placement_type want;
      if (!reset && rsp_valid) begin
         if (expected_placements.size() == 0) begin
            $error("result strobe with no request outstanding");
            errors++;
         end else begin
            want = expected_placements.pop_front();
            check_field("placed_cpu", want.placed_cpu, rsp_placed_cpu);
            check_field("steal_request", want.steal_request, rsp_steal_request);
            check_field("steal_source", want.steal_source, rsp_steal_source);
            check_field("imbalanced", want.imbalanced, rsp_imbalanced);
            check_field("total_load", want.total_load, rsp_total_load);
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("cpu_placement_and_balance_top verification failed");
      $finish;
   end

   // register defaults: one live CPU, ticks have no effect
   task automatic test_register_defaults();
      send_request(FUNC_ENQUEUE, 8'h00, 3'd0);
      send_request(FUNC_ENQUEUE, 8'h04, 3'd5);
      send_request(FUNC_TICK, 8'h00, 3'd0);
      send_request(FUNC_REMOVE, 8'h00, 3'd2);
      wait_idle();
   endtask

   // placement rules, empty remove, steal decisions, unused code
   task automatic test_placement_directed();
      set_config(8, 1, 0);
      send_request(FUNC_ENQUEUE, 8'h01, 3'd0);
      send_request(FUNC_ENQUEUE, 8'h80, 3'd0);
      send_request(FUNC_ENQUEUE, 8'hFE, 3'd0);
      send_request(FUNC_ENQUEUE, 8'h00, 3'd0);
      send_request(FUNC_ENQUEUE, 8'hFF, 3'd0);
      send_request(FUNC_REMOVE, 8'h00, 3'd5);
      send_request(FUNC_REMOVE, 8'h00, 3'd7);
      send_request(FUNC_TICK, 8'h00, 3'd3);
      send_request(FUNC_TICK, 8'h00, 3'd0);
      send_request(FUNC_UNUSED, 8'hAA, 3'd6);
      wait_idle();
      // three live CPUs: masks outside them, ticks and removes on idle slots
      set_config(3, 3, 2);
      send_request(FUNC_ENQUEUE, 8'h08, 3'd0);
      send_request(FUNC_ENQUEUE, 8'hF0, 3'd0);
      send_request(FUNC_ENQUEUE, 8'h00, 3'd0);
      send_request(FUNC_TICK, 8'h00, 3'd6);
      send_request(FUNC_REMOVE, 8'h00, 3'd7);
      repeat (3) send_request(FUNC_TICK, 8'h00, 3'd2);
      wait_idle();
   endtask

   // zero and oversized active count, zero period, lowered period, max margin
   task automatic test_register_extremes();
      set_config(0, 0, 15);
      send_request(FUNC_ENQUEUE, 8'h00, 3'd0);
      send_request(FUNC_TICK, 8'h00, 3'd0);
      wait_idle();
      set_config(15, 255, 0);
      repeat (3) send_request(FUNC_TICK, 8'h00, 3'd4);
      wait_idle();
      set_config(8, 2, 0);
      send_request(FUNC_TICK, 8'h00, 3'd4);
      wait_idle();
      set_config(8, 1, 15);
      send_request(FUNC_TICK, 8'h00, 3'd1);
      send_request(FUNC_ENQUEUE, 8'h80, 3'd0);
      wait_idle();
   endtask

   // random traffic over several register settings
   task automatic test_random_traffic();
      int pick;
      int active;
      int period;
      int margin;
      logic [1:0] func;
      logic [7:0] mask;
      for (int phase = 0; phase < 8; phase++) begin
         pick = $urandom_range(0, 9);
         active = (pick == 0) ? $urandom_range(0, 15) : $urandom_range(2, 8);
         pick = $urandom_range(0, 9);
         if (pick < 6) period = $urandom_range(1, 4);
         else if (pick < 9) period = $urandom_range(5, 255);
         else period = 0;
         margin = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 15);
         set_config(active, period, margin);
         for (int k = 0; k < 100; k++) begin
            // stretches of back-to-back requests
            if (k % 16 == 0) no_gap = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            mask = $urandom_range(0, 255);
            if (pick < 45) begin
               func = FUNC_ENQUEUE;
               case ($urandom_range(0, 2))
                  0: mask = 8'h00;
                  1: mask = 8'h01 << $urandom_range(0, 7);
                  default: ;
               endcase
            end else if (pick < 70) begin
               func = FUNC_REMOVE;
            end else if (pick < 95) begin
               func = FUNC_TICK;
            end else begin
               func = FUNC_UNUSED;
            end
            send_request(func, mask, 3'($urandom_range(0, 7)));
         end
         no_gap = 1'b0;
         wait_idle();
      end
   endtask

   // main sequence
   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_func <= FUNC_ENQUEUE;
      req_affinity_mask <= 8'h00;
      req_cpu_id <= 3'd0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_ACTIVE_CPUS;
      csr_wdata <= 8'h00;
      cfg_active = ACTIVE_CPUS_RST;
      cfg_period = BALANCE_PERIOD_RST;
      cfg_margin = IMBALANCE_MARGIN_RST;
      foreach (mirror_load[i]) begin
         mirror_load[i] = '0;
         mirror_tick[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_register_defaults();
      test_placement_directed();
      test_register_extremes();
      test_random_traffic();

      wait_idle();
      repeat (LATENCY + 5) @(posedge clock);
      if (errors == 0) begin
         $display("cpu_placement_and_balance_top verification clean");
      end else begin
         $display("cpu_placement_and_balance_top verification failed");
      end
      $finish;
   end

endmodule
